/* hw/rtl/qrs_pkg.sv */
// Shared widths, result codes and stage payload types for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W      = 16;
  localparam int FRAC_W      = 8;
  localparam int ROOT_FRAC_W = 2 * FRAC_W;
  localparam int ROOT_W      = 32;
  localparam int DISC_W      = 2 * COEF_W + 2;
  localparam int SQRT_W      = DISC_W / 2;
  localparam int NUM_W       = SQRT_W + 1;
  localparam int DEN_W       = COEF_W + 1;
  localparam int DIVN_W      = NUM_W + ROOT_FRAC_W;

  typedef enum logic [1:0] {
    KIND_TWO   = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_DEGEN = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DISC_W-1:0] disc;
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
  } disc_t;

endpackage

/* hw/rtl/qrs_disc.sv */
// Two stage discriminant unit: products, then b*b - 4ac.
module qrs_disc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic [qrs_pkg::COEF_W-1:0] coef_c,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qrs_pkg::disc_t             out_data
);
  import qrs_pkg::*;

  logic                  v1_r, v2_r, en1, en2;
  logic [2*COEF_W-1:0]   bb_r, ac_r;
  logic [COEF_W-1:0]     a1_r, b1_r;
  logic [DISC_W-1:0]     bb_ext, ac_ext, disc_nxt;
  disc_t                 d2_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      bb_r <= $signed(coef_b) * $signed(coef_b);
      ac_r <= $signed(coef_a) * $signed(coef_c);
      a1_r <= coef_a;
      b1_r <= coef_b;
    end
  end

  assign bb_ext   = {{(DISC_W-2*COEF_W){bb_r[2*COEF_W-1]}}, bb_r};
  assign ac_ext   = {{(DISC_W-2*COEF_W){ac_r[2*COEF_W-1]}}, ac_r};
  assign disc_nxt = bb_ext - (ac_ext << 2);

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      d2_r.disc <= disc_nxt;
      d2_r.a    <= a1_r;
      d2_r.b    <= b1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = d2_r;

endmodule

/* hw/rtl/qrs_sqrt.sv */
// Pipelined floored square root, one result bit per stage.
module qrs_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qrs_pkg::disc_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qrs_pkg::SQRT_W-1:0] out_root,
  output qrs_pkg::disc_t             out_data
);
  import qrs_pkg::*;

  localparam int SQ_N   = SQRT_W;
  localparam int REMS_W = SQRT_W + 3;

  logic              v_r    [SQ_N];
  logic              vin    [SQ_N];
  logic              en     [SQ_N+1];
  logic [DISC_W-1:0] rad_r  [SQ_N];
  logic [DISC_W-1:0] rad_i  [SQ_N];
  logic [REMS_W-3:0] rem_r  [SQ_N];
  logic [REMS_W-3:0] rem_i  [SQ_N];
  logic [SQRT_W-1:0] root_r [SQ_N];
  logic [SQRT_W-1:0] root_i [SQ_N];
  disc_t             side_r [SQ_N];
  disc_t             side_i [SQ_N];

  assign en[SQ_N] = out_ready;

  for (genvar i = 0; i < SQ_N; i++) begin : g_stage
    logic [REMS_W-1:0] cur, test, diff;
    logic              ge;

    if (i == 0) begin : g_first
      // A negative discriminant has no real root; its root value is unused.
      assign vin[i]    = in_valid;
      assign rad_i[i]  = in_data.disc[DISC_W-1] ? '0 : in_data.disc;
      assign rem_i[i]  = '0;
      assign root_i[i] = '0;
      assign side_i[i] = in_data;
    end else begin : g_next
      assign vin[i]    = v_r[i-1];
      assign rad_i[i]  = rad_r[i-1];
      assign rem_i[i]  = rem_r[i-1];
      assign root_i[i] = root_r[i-1];
      assign side_i[i] = side_r[i-1];
    end

    assign en[i] = !v_r[i] || en[i+1];
    assign cur   = {rem_i[i], rad_i[i][DISC_W-1 -: 2]};
    assign test  = {1'b0, root_i[i], 2'b01};
    assign ge    = cur >= test;
    assign diff  = cur - test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en[i]) begin
        v_r[i] <= vin[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i] && vin[i]) begin
        rad_r[i]  <= rad_i[i] << 2;
        rem_r[i]  <= ge ? diff[REMS_W-3:0] : cur[REMS_W-3:0];
        root_r[i] <= {root_i[i][SQRT_W-2:0], ge};
        side_r[i] <= side_i[i];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[SQ_N-1];
  assign out_root  = root_r[SQ_N-1];
  assign out_data  = side_r[SQ_N-1];

endmodule

/* hw/rtl/qrs_div.sv */
// Root forming: numerator set-up, two restoring dividers and saturation.
module qrs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qrs_pkg::SQRT_W-1:0] in_root,
  input  qrs_pkg::disc_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qrs_pkg::kind_t             out_kind,
  output logic [qrs_pkg::ROOT_W-1:0] out_plus,
  output logic [qrs_pkg::ROOT_W-1:0] out_minus,
  output logic [qrs_pkg::DISC_W-1:0] out_disc
);
  import qrs_pkg::*;

  localparam int DV_N = DIVN_W;

  function automatic logic [ROOT_W-1:0] sat_root(input logic [DIVN_W-1:0] q,
                                                 input logic neg);
    logic [ROOT_W-1:0] r;
    if (!neg) begin
      r = (|q[DIVN_W-1:ROOT_W-1]) ? {1'b0, {(ROOT_W-1){1'b1}}} : q[ROOT_W-1:0];
    end else if ((|q[DIVN_W-1:ROOT_W]) || (q[ROOT_W-1] && (|q[ROOT_W-2:0]))) begin
      r = {1'b1, {(ROOT_W-1){1'b0}}};
    end else begin
      r = -q[ROOT_W-1:0];
    end
    return r;
  endfunction

  // Per stage: index 0 is the set-up register, 1..DV_N the divider steps.
  logic              v_r    [DV_N+1];
  logic              en     [DV_N+2];
  logic [DIVN_W-1:0] qp_r   [DV_N+1];
  logic [DIVN_W-1:0] qm_r   [DV_N+1];
  logic [DEN_W-1:0]  rp_r   [DV_N+1];
  logic [DEN_W-1:0]  rm_r   [DV_N+1];
  logic [DEN_W-1:0]  den_r  [DV_N+1];
  logic              negp_r [DV_N+1];
  logic              negm_r [DV_N+1];
  kind_t             kind_r [DV_N+1];
  logic [DISC_W-1:0] disc_r [DV_N+1];

  logic              ov_r;
  kind_t             okind_r;
  logic [ROOT_W-1:0] oplus_r, ominus_r;
  logic [DISC_W-1:0] odisc_r;

  logic [NUM_W-1:0]  nb, sx, num_p, num_m, mag_p, mag_m;
  logic [DEN_W-1:0]  a2, dmag;
  kind_t             kind_nxt;

  assign nb    = -{{(NUM_W-COEF_W){in_data.b[COEF_W-1]}}, in_data.b};
  assign sx    = {1'b0, in_root};
  assign num_p = nb + sx;
  assign num_m = nb - sx;
  assign mag_p = num_p[NUM_W-1] ? -num_p : num_p;
  assign mag_m = num_m[NUM_W-1] ? -num_m : num_m;
  assign a2    = {in_data.a, 1'b0};
  assign dmag  = in_data.a[COEF_W-1] ? -a2 : a2;

  always_comb begin
    if (in_data.a == '0) begin
      kind_nxt = KIND_DEGEN;
    end else if (in_data.disc[DISC_W-1]) begin
      kind_nxt = KIND_NONE;
    end else if (in_data.disc == '0) begin
      kind_nxt = KIND_ONE;
    end else begin
      kind_nxt = KIND_TWO;
    end
  end

  assign en[DV_N+1] = !ov_r || out_ready;
  assign en[0]      = !v_r[0] || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      qp_r[0]   <= {mag_p, {ROOT_FRAC_W{1'b0}}};
      qm_r[0]   <= {mag_m, {ROOT_FRAC_W{1'b0}}};
      rp_r[0]   <= '0;
      rm_r[0]   <= '0;
      den_r[0]  <= dmag;
      negp_r[0] <= num_p[NUM_W-1] ^ in_data.a[COEF_W-1];
      negm_r[0] <= num_m[NUM_W-1] ^ in_data.a[COEF_W-1];
      kind_r[0] <= kind_nxt;
      disc_r[0] <= in_data.disc;
    end
  end

  for (genvar i = 1; i <= DV_N; i++) begin : g_step
    logic [DEN_W:0] cur_p, cur_m, dif_p, dif_m;
    logic           ge_p, ge_m;

    assign en[i]  = !v_r[i] || en[i+1];
    assign cur_p  = {rp_r[i-1], qp_r[i-1][DIVN_W-1]};
    assign cur_m  = {rm_r[i-1], qm_r[i-1][DIVN_W-1]};
    assign ge_p   = cur_p >= {1'b0, den_r[i-1]};
    assign ge_m   = cur_m >= {1'b0, den_r[i-1]};
    assign dif_p  = cur_p - {1'b0, den_r[i-1]};
    assign dif_m  = cur_m - {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en[i]) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i] && v_r[i-1]) begin
        qp_r[i]   <= {qp_r[i-1][DIVN_W-2:0], ge_p};
        qm_r[i]   <= {qm_r[i-1][DIVN_W-2:0], ge_m};
        rp_r[i]   <= ge_p ? dif_p[DEN_W-1:0] : cur_p[DEN_W-1:0];
        rm_r[i]   <= ge_m ? dif_m[DEN_W-1:0] : cur_m[DEN_W-1:0];
        den_r[i]  <= den_r[i-1];
        negp_r[i] <= negp_r[i-1];
        negm_r[i] <= negm_r[i-1];
        kind_r[i] <= kind_r[i-1];
        disc_r[i] <= disc_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en[DV_N+1]) begin
      ov_r <= v_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en[DV_N+1] && v_r[DV_N]) begin
      okind_r <= kind_r[DV_N];
      odisc_r <= disc_r[DV_N];
      if (kind_r[DV_N] == KIND_NONE || kind_r[DV_N] == KIND_DEGEN) begin
        oplus_r  <= '0;
        ominus_r <= '0;
      end else begin
        oplus_r  <= sat_root(qp_r[DV_N], negp_r[DV_N]);
        ominus_r <= sat_root(qm_r[DV_N], negm_r[DV_N]);
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_plus  = oplus_r;
  assign out_minus = ominus_r;
  assign out_disc  = odisc_r;

endmodule

/* hw/rtl/quadratic_root_solver.sv */
// Top level of the quadratic root solver: discriminant, square root and divider pipelines.
// An accepted word passes the product and discriminant stages, the square root stages and
// the divider set-up, step and output registers. Throughput is one word per cycle while
// out_stall is low; every stage has its own valid bit and moves whenever the stage after
// it is empty or moving, so bubbles close up behind a stalled output.
// The synchronous active-low reset clears all valid bits; data registers are not reset.
module quadratic_root_solver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [qrs_pkg::COEF_W-1:0] in_coef_a,
  input  logic [qrs_pkg::COEF_W-1:0] in_coef_b,
  input  logic [qrs_pkg::COEF_W-1:0] in_coef_c,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_root_kind,
  output logic [qrs_pkg::ROOT_W-1:0] out_root_plus,
  output logic [qrs_pkg::ROOT_W-1:0] out_root_minus,
  output logic [qrs_pkg::DISC_W-1:0] out_disc_value
);
  import qrs_pkg::*;

  logic              in_ready;
  logic              d_valid, d_ready;
  disc_t             d_data;
  logic              s_valid, s_ready;
  logic [SQRT_W-1:0] s_root;
  disc_t             s_data;
  kind_t             kind;

  // The discriminant is formed exactly from the signed products.
  qrs_disc u_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coef_a    (in_coef_a),
    .coef_b    (in_coef_b),
    .coef_c    (in_coef_c),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  // Floored integer square root, one digit pair per stage.
  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_root),
    .out_data  (s_data)
  );

  // Both roots are divided side by side on magnitudes, then signed and saturated.
  qrs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_root   (s_root),
    .in_data   (s_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_kind  (kind),
    .out_plus  (out_root_plus),
    .out_minus (out_root_minus),
    .out_disc  (out_disc_value)
  );

  assign in_stall      = !in_ready;
  assign out_root_kind = kind;

  // Result classes must agree with the discriminant and the root values.
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind == KIND_DEGEN) |-> (out_root_plus == '0 && out_root_minus == '0))
    else $error("degenerate word carries non-zero roots");

  a_none_neg : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind == KIND_NONE) |->
      (out_disc_value[DISC_W-1] && out_root_plus == '0 && out_root_minus == '0))
    else $error("no-root word inconsistent with discriminant");

  a_one_equal : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind == KIND_ONE) |->
      (out_disc_value == '0 && out_root_plus == out_root_minus))
    else $error("repeated-root word has differing roots");

  a_two_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind == KIND_TWO) |->
      (!out_disc_value[DISC_W-1] && out_disc_value != '0))
    else $error("two-root word without positive discriminant");

endmodule

/* verif/quadratic_root_solver_test.sv */
// Self-checking testbench for the quadratic root solver: directed corners, then random words.
module quadratic_root_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qrs_pkg::*;

  // Each result depends only on its own coefficient word, so the expected result of each
  // accepted word can be worked out when it is accepted and queued until its result word leaves.
  typedef struct packed {
    kind_t             kind;
    logic [ROOT_W-1:0] plus;
    logic [ROOT_W-1:0] minus;
    logic [DISC_W-1:0] disc;
  } roots_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [COEF_W-1:0] in_coef_a;
  logic [COEF_W-1:0] in_coef_b;
  logic [COEF_W-1:0] in_coef_c;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_root_kind;
  logic [ROOT_W-1:0] out_root_plus;
  logic [ROOT_W-1:0] out_root_minus;
  logic [DISC_W-1:0] out_disc_value;

  roots_t pending_roots[$];
  int     mismatch_count;
  int     orphan_count;
  bit     stall_enable;

  quadratic_root_solver u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_root_kind  (out_root_kind),
    .out_root_plus  (out_root_plus),
    .out_root_minus (out_root_minus),
    .out_disc_value (out_disc_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floored, by the usual bit-pair method.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale the numerator to Q16.16, divide truncating toward zero, then clamp to 32 bits.
  function automatic logic [ROOT_W-1:0] clamp_quotient(longint num, longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[ROOT_W-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic [COEF_W-1:0] ra, logic [COEF_W-1:0] rb,
                                             logic [COEF_W-1:0] rc);
    roots_t r;
    longint a;
    longint b;
    longint c;
    longint d;
    longint s;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    c = longint'($signed(rc));
    d = b * b - 4 * a * c;
    r.plus  = '0;
    r.minus = '0;
    r.disc  = d[DISC_W-1:0];
    // A zero leading coefficient wins over the sign of the discriminant.
    if (a == 0) begin
      r.kind = KIND_DEGEN;
    end else if (d < 0) begin
      r.kind = KIND_NONE;
    end else begin
      s       = longint'(floor_sqrt(d));
      r.kind  = (d > 0) ? KIND_TWO : KIND_ONE;
      r.plus  = clamp_quotient(-b + s, 2 * a);
      r.minus = clamp_quotient(-b - s, 2 * a);
    end
    return r;
  endfunction

  // Sends one coefficient word and holds it until the solver takes it. The valid line is
  // only lowered by the caller, so back-to-back words never see valid drop within a step.
  task automatic send_coefs(logic [COEF_W-1:0] ca, logic [COEF_W-1:0] cb,
                            logic [COEF_W-1:0] cc);
    in_valid  <= 1'b1;
    in_coef_a <= ca;
    in_coef_b <= cb;
    in_coef_c <= cc;
    do @(posedge clk); while (in_stall);
    pending_roots.push_back(solve_quadratic(ca, cb, cc));
  endtask

  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of random length with gaps between them; some bursts have no gaps at all.
  task automatic send_burst_gap();
    if ($urandom_range(0, 9) < 2) idle_input($urandom_range(1, 8));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // Corners: the extremes of every coefficient, each kind of result, a discriminant so small
  // that its floored root is zero, and a quotient large enough to saturate toward the maximum.
  task automatic test_directed();
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0000, 16'h8000, 16'h7fff);
    send_coefs(16'h0100, 16'h0000, 16'hff00);
    send_coefs(16'h0100, 16'hfe00, 16'h0100);
    send_coefs(16'h0100, 16'h0000, 16'h0100);
    send_coefs(16'h0100, 16'h0001, 16'h0000);
    send_coefs(16'h0001, 16'h0002, 16'h0001);
    send_coefs(16'h0001, 16'h7fff, 16'h0000);
    send_coefs(16'h0001, 16'h8000, 16'h0000);
    send_coefs(16'hffff, 16'h7fff, 16'h0000);
    send_coefs(16'hffff, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h0000, 16'h7fff);
    send_coefs(16'h0001, 16'h0001, 16'h0000);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'h0400, 16'h0400, 16'h0100);
    send_coefs(16'hfc00, 16'h0400, 16'hff00);
    idle_input(1);
  endtask

  // Perfect squares give repeated roots: a(x - r)^2 expanded with small integer terms.
  task automatic test_repeated_roots(int count);
    int   ka;
    int   kr;
    logic [COEF_W-1:0] cb;
    logic [COEF_W-1:0] cc;
    for (int i = 0; i < count; i++) begin
      ka = int'($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
      kr = $signed($urandom_range(0, 15)) - 8;
      cb = 16'(-2 * ka * kr);
      cc = 16'(ka * kr * kr);
      send_coefs(16'(ka), cb, cc);
      send_burst_gap();
    end
    idle_input(1);
  endtask

  // Mostly fully random coefficients, with some small ones and some zero leading terms.
  task automatic test_random_words(int count);
    logic [COEF_W-1:0] ca;
    logic [COEF_W-1:0] cb;
    logic [COEF_W-1:0] cc;
    for (int i = 0; i < count; i++) begin
      ca = 16'($urandom());
      cb = 16'($urandom());
      cc = 16'($urandom());
      case ($urandom_range(0, 9)) inside
        0: ca = '0;
        1, 2: begin
          ca = 16'($signed($urandom_range(0, 1023)) - 512);
          cb = 16'($signed($urandom_range(0, 1023)) - 512);
          cc = 16'($signed($urandom_range(0, 1023)) - 512);
        end
        default: ;
      endcase
      send_coefs(ca, cb, cc);
      send_burst_gap();
      // Hold off once, halfway through, until the pipeline is empty, so it restarts from idle.
      if (i == count / 2) wait_drained();
    end
    idle_input(1);
  endtask

  // The receiver stalls on its own pattern: long quiet stretches, then spells of random stalls.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) stall_enable = ~stall_enable;
      out_stall <= stall_enable ? ($urandom_range(0, 2) == 0) : 1'b0;
    end
  end

  // Each accepted result word is matched against the oldest expectation, field by field.
  initial begin
    roots_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_roots.size() == 0) begin
          orphan_count++;
          if (orphan_count + mismatch_count <= 10)
            $display("Unexpected result word: kind %0d plus %h minus %h disc %h",
                     out_root_kind, out_root_plus, out_root_minus, out_disc_value);
        end else begin
          want = pending_roots.pop_front();
          if (out_root_kind !== want.kind || out_root_plus !== want.plus ||
              out_root_minus !== want.minus || out_disc_value !== want.disc) begin
            mismatch_count++;
            if (mismatch_count + orphan_count <= 10)
              $display("Mismatch: expected kind %0d plus %h minus %h disc %h, got %0d %h %h %h",
                       want.kind, want.plus, want.minus, want.disc, out_root_kind,
                       out_root_plus, out_root_minus, out_disc_value);
          end
        end
      end
    end
  end

  // Watchdog: far beyond what a thousand words take with stalls and gaps.
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int drain_guard;
    stall_enable   = 1'b0;
    mismatch_count = 0;
    orphan_count   = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_coef_a <= '0;
    in_coef_b <= '0;
    in_coef_c <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_repeated_roots(100);
    test_random_words(900);

    // Wait for the last words to leave, then keep watching for any stray ones.
    wait_drained();
    drain_guard = 0;
    while (drain_guard < 200) begin
      @(posedge clk);
      drain_guard++;
    end
    if (mismatch_count == 0 && orphan_count == 0 && pending_roots.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
